>>> hdl/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and cell bus types.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 8;

	typedef enum logic [1:0] {
		ACT_INSERT       = 2'd0,
		ACT_POP          = 2'd1,
		ACT_REMOVE_EXACT = 2'd2,
		ACT_POP_MIN      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// What a cell shows its neighbors and the top level.
	typedef struct packed {
		logic                     valid;
		logic                     ge;
		logic                     gt;
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
	} cell_view_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic                     head;
		logic                     found;
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
	} cell_cmd_t;

	localparam cell_view_t HEAD_VIEW = '{valid: 1'b1, ge: 1'b1, gt: 1'b1,
		data: '0, prio: '0};
	localparam cell_view_t TAIL_VIEW = '{valid: 1'b0, ge: 1'b0, gt: 1'b0,
		data: '0, prio: '0};

endpackage

>>> hdl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps
interface spq_req_if;
	import spq_pkg::*;
	logic                     valid;
	logic                     ready;
	action_t                  action;
	logic signed [DATA_W-1:0] item_data;
	logic [PRIO_W-1:0]        item_priority;
	modport source (output valid, action, item_data, item_priority, input ready);
	modport sink (input valid, action, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_data;
	status_t                  status;
	logic [OCC_W-1:0]         occupancy;
	modport source (output valid, result_data, status, occupancy, input ready);
	modport sink (input valid, result_data, status, occupancy, output ready);
endinterface

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
module spq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spq_pkg::cell_cmd_t               cmd,
	input  logic [spq_pkg::PRIO_W-1:0]        key,
	input  spq_pkg::cell_view_t              left,
	input  spq_pkg::cell_view_t              right,
	output spq_pkg::cell_view_t              view,
	output logic signed [spq_pkg::DATA_W-1:0] hit_data
);
	import spq_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic [PRIO_W-1:0]        prio_q;
	logic                     match;
	logic                     left_match;
	logic                     shift;

	always_comb begin
		view.valid = valid_q;
		view.ge    = valid_q && (prio_q >= key);
		view.gt    = valid_q && (prio_q > key);
		view.data  = data_q;
		view.prio  = prio_q;
	end

	always_comb begin
		match      = view.ge && !view.gt;
		left_match = left.ge && !left.gt;
		hit_data   = (match && !left_match) ? data_q : '0;
		// Slots from the removed one onward pull from the right.
		shift      = cmd.head || (view.ge ? !view.gt : cmd.found);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (!left.ge) begin
				valid_q <= left.valid;
			end else if (!view.ge) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.rem && shift) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!left.ge) begin
				data_q <= left.data;
				prio_q <= left.prio;
			end else if (!view.ge) begin
				data_q <= cmd.data;
				prio_q <= cmd.prio;
			end
		end else if (cmd.rem && shift) begin
			data_q <= right.data;
			prio_q <= right.prio;
		end
	end

endmodule

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: command decode, cell chain, response.
`timescale 1ns / 1ps
// Sorted priority queue of CAPACITY entries held in a chain of cells, highest
// priority at the head, equal priorities in arrival order. Every cell compares
// its priority against the request at once and shifts one place left or right
// in the same cycle: a request accepted at one edge has its response word
// registered at that same edge and offered from the next cycle on, and a new
// request is taken every cycle while the response side keeps up. Each request
// yields exactly one response word with the removed data (zero if none), a
// status and the count of entries held afterwards. The queue comes up empty
// after reset.
module sorted_priority_queue (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);
	import spq_pkg::*;

	cell_cmd_t                cmd;
	cell_view_t               views [CAPACITY];
	cell_view_t               left_v [CAPACITY];
	cell_view_t               right_v [CAPACITY];
	logic signed [DATA_W-1:0] hits [CAPACITY];

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_data_q;
	status_t                  rsp_status_q;
	logic [OCC_W-1:0]         rsp_occ_q;

	logic                     fire;
	logic                     empty;
	logic                     full;
	logic                     found;
	logic signed [DATA_W-1:0] hit_or;
	status_t                  status;
	logic signed [DATA_W-1:0] result;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		found  = 1'b0;
		hit_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found  = found | (views[i].ge && !views[i].gt);
			hit_or = hit_or | hits[i];
		end
	end

	always_comb begin
		status = ST_OK;
		unique case (req.action)
			ACT_INSERT: begin
				if (full) status = ST_FULL;
			end
			ACT_POP: begin
				if (empty) status = ST_EMPTY;
			end
			ACT_REMOVE_EXACT: begin
				if (empty) status = ST_EMPTY;
				else if (!found) status = ST_NOT_FOUND;
			end
			ACT_POP_MIN: begin
				if (empty) status = ST_EMPTY;
				else if (!views[0].ge) status = ST_NOT_FOUND;
			end
			default: status = ST_OK;
		endcase
	end

	always_comb begin
		cmd.ins   = fire && (req.action == ACT_INSERT) && (status == ST_OK);
		cmd.rem   = fire && (req.action != ACT_INSERT) && (status == ST_OK);
		cmd.head  = (req.action != ACT_REMOVE_EXACT);
		cmd.found = found;
		cmd.data  = req.item_data;
		cmd.prio  = req.item_priority;

		if (status != ST_OK || req.action == ACT_INSERT) begin
			result = '0;
		end else if (cmd.head) begin
			result = views[0].data;
		end else begin
			result = hit_or;
		end

		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign left_v[g] = HEAD_VIEW;
		end else begin : g_mid
			assign left_v[g] = views[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign right_v[g] = TAIL_VIEW;
		end else begin : g_next
			assign right_v[g] = views[g+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.key      (req.item_priority),
			.left     (left_v[g]),
			.right    (right_v[g]),
			.view     (views[g]),
			.hit_data (hits[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response word until it is taken.
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_data_q   <= result;
			rsp_status_q <= status;
			rsp_occ_q    <= OCC_W'(count_next);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_data = rsp_data_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.occupancy   = rsp_occ_q;

endmodule

>>> verif/sorted_priority_queue_test.sv
// Testbench of the sorted priority queue: random and directed requests checked against a model.
`timescale 1ns / 1ps
module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int RANDOM_REQUESTS = 1200;
	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 200000;

	typedef struct {
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} response_t;

	// Sorted queue model and the responses it still waits for.
	class queue_tracker;
		entry_t    entries[$];
		response_t awaited[$];
		int        mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Take the entry at pos out of the model and return its data.
		function logic signed [DATA_W-1:0] take_entry(int pos);
			logic signed [DATA_W-1:0] d;
			d = entries[pos].data;
			entries.delete(pos);
			return d;
		endfunction

		function void note_request(action_t act, logic signed [DATA_W-1:0] d,
				logic [PRIO_W-1:0] p);
			response_t r;
			entry_t    e;
			int        pos;
			r.data = '0;
			r.status = ST_OK;
			if (act == ACT_INSERT) begin
				if (entries.size() >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// Land behind every entry of equal or higher priority.
					pos = 0;
					while (pos < entries.size() && entries[pos].prio >= p)
						pos++;
					e.prio = p;
					e.data = d;
					entries.insert(pos, e);
				end
			end else if (entries.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				case (act)
					ACT_POP: begin
						r.data = take_entry(0);
					end
					ACT_REMOVE_EXACT: begin
						pos = -1;
						foreach (entries[i])
							if (pos < 0 && entries[i].prio == p)
								pos = i;
						if (pos < 0)
							r.status = ST_NOT_FOUND;
						else
							r.data = take_entry(pos);
					end
					default: begin
						if (entries[0].prio >= p)
							r.data = take_entry(0);
						else
							r.status = ST_NOT_FOUND;
					end
				endcase
			end
			r.occupancy = OCC_W'(entries.size());
			awaited.push_back(r);
		endfunction

		function void check_response(logic signed [DATA_W-1:0] d, status_t s,
				logic [OCC_W-1:0] occ);
			response_t r;
			if (awaited.size() == 0) begin
				$error("response word with none outstanding: data %0d status %s occupancy %0d",
					d, s.name(), occ);
				mismatches++;
				return;
			end
			r = awaited.pop_front();
			if (d !== r.data) begin
				$error("result_data: expected %0d, got %0d", r.data, d);
				mismatches++;
			end
			if (s !== r.status) begin
				$error("status: expected %s, got %s", r.status.name(), s.name());
				mismatches++;
			end
			if (occ !== r.occupancy) begin
				$error("occupancy: expected %0d, got %0d", r.occupancy, occ);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	bit   idle_on = 1'b1;
	bit   hold_request = 1'b0;
	queue_tracker tracker = new();

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	sorted_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one request word and return at the edge that accepts it.
	task automatic put_request(action_t act, logic signed [DATA_W-1:0] d,
			logic [PRIO_W-1:0] p);
		while (idle_on && $urandom_range(99) < 9) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.action        <= act;
		req_ch.item_data     <= d;
		req_ch.item_priority <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_request(act, d, p);
	endtask

	function automatic logic [PRIO_W-1:0] pick_priority();
		case ($urandom_range(3))
			0: return PRIO_W'($urandom);
			1: return PRIO_W'($urandom_range(3));
			2: return PRIO_W'(252 + $urandom_range(3));
			default: return PRIO_W'($urandom_range(7) * 36);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_data();
		case ($urandom_range(7))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_directed();
		logic [PRIO_W-1:0]        p;
		logic signed [DATA_W-1:0] d;
		// Removals of every kind on an empty queue.
		put_request(ACT_POP, '0, '0);
		put_request(ACT_REMOVE_EXACT, '1, '1);
		put_request(ACT_POP_MIN, {1'b0, {(DATA_W-1){1'b1}}}, '0);
		// Fill up, with equal priorities arriving in turn.
		for (int i = 0; i < CAPACITY; i++) begin
			case (i % 4)
				0: p = '1;
				1: p = '0;
				default: p = 8'd128;
			endcase
			case (i)
				0: d = {1'b1, {(DATA_W-1){1'b0}}};
				1: d = {1'b0, {(DATA_W-1){1'b1}}};
				2: d = '1;
				3: d = '0;
				default: d = $urandom;
			endcase
			put_request(ACT_INSERT, d, p);
		end
		put_request(ACT_INSERT, 32'sd123, 8'd7);
		put_request(ACT_REMOVE_EXACT, '0, 8'd128);
		put_request(ACT_REMOVE_EXACT, '0, 8'd77);
		put_request(ACT_POP_MIN, '0, '1);
		put_request(ACT_REMOVE_EXACT, '0, '0);
		put_request(ACT_POP, '0, '0);
	endtask

	task automatic run_random(int count);
		int      bias;
		action_t act;
		for (int n = 0; n < count; n++) begin
			// Shift between filling, draining and balanced traffic.
			if (n % 64 == 0)
				bias = 25 + 25 * $urandom_range(2);
			if (n == 300)
				hold_request = 1'b1;
			idle_on = !(n >= 600 && n < 850);
			if ($urandom_range(99) < bias)
				act = ACT_INSERT;
			else
				act = action_t'($urandom_range(3, 1));
			put_request(act, pick_data(), pick_priority());
		end
	endtask

	// Response side: check accepted words and stall at random.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_response(rsp_ch.result_data, rsp_ch.status,
					rsp_ch.occupancy);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(idle_on && $urandom_range(99) < 9);
			end
		end
	end

	initial begin
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.action        <= ACT_INSERT;
		req_ch.item_data     <= '0;
		req_ch.item_priority <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(RANDOM_REQUESTS);
		req_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
